// ===== hdl/fsac_pkg.sv =====
// Shared types and constants of the fuzzy speed and angle controller.
package fsac_pkg;

  localparam int SPEED_W    = 13;
  localparam int LIMIT_W    = 12;
  localparam int ANGREG_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POWER_W    = 16;

  localparam int MU_W     = 17;
  localparam int MUQ_W    = 16;
  localparam int NSETS    = 5;
  localparam int NLANES   = 10;
  localparam int NRULES   = 25;
  localparam int SUM_W    = 21;
  localparam int SQX_W    = 38;
  localparam int ROOT_W   = 19;
  localparam int SQ_IT    = 19;
  localparam int SQ_ST    = 10;
  localparam int NUM_W    = 23;
  localparam int DEN_W    = 22;

  localparam logic [MU_W-1:0] MU_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT     = 3'd0,
    CFG_SPEED_KNEE      = 3'd1,
    CFG_ANGLE_KNEE_LOW  = 3'd2,
    CFG_ANGLE_CENTER    = 3'd3,
    CFG_ANGLE_KNEE_HIGH = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MU_ZERO = 2'd0,
    MU_FULL = 2'd1,
    MU_DIV  = 2'd2
  } mu_kind_t;

  typedef struct packed {
    logic [2:0] spd;
    logic [2:0] ang;
    logic [2:0] cls;
  } rule_t;

  localparam rule_t RULES [NRULES] = '{
    '{3'd0, 3'd4, 3'd1}, '{3'd0, 3'd3, 3'd3}, '{3'd0, 3'd2, 3'd4}, '{3'd0, 3'd1, 3'd4},
    '{3'd0, 3'd0, 3'd4},
    '{3'd1, 3'd4, 3'd0}, '{3'd1, 3'd3, 3'd2}, '{3'd1, 3'd2, 3'd3}, '{3'd1, 3'd1, 3'd4},
    '{3'd1, 3'd0, 3'd4},
    '{3'd2, 3'd4, 3'd0}, '{3'd2, 3'd3, 3'd1}, '{3'd2, 3'd2, 3'd2}, '{3'd2, 3'd1, 3'd3},
    '{3'd2, 3'd0, 3'd4},
    '{3'd3, 3'd4, 3'd0}, '{3'd3, 3'd3, 3'd0}, '{3'd3, 3'd2, 3'd1}, '{3'd3, 3'd1, 3'd2},
    '{3'd3, 3'd0, 3'd4},
    '{3'd4, 3'd4, 3'd0}, '{3'd4, 3'd3, 3'd0}, '{3'd4, 3'd2, 3'd0}, '{3'd4, 3'd1, 3'd1},
    '{3'd4, 3'd0, 3'd3}
  };

endpackage

// ===== hdl/fuzzy_speed_angle_controller.sv =====
// Pipelined two-input fuzzy drive controller with configurable set corners.
// The pipeline runs from the speed clamp through the membership dividers, rule minimums,
// class sums, square roots, weighted sums and the final rounding division to the strobe.
// Throughput: one transfer per cycle while busy is low; busy clears after reset ends.
// Reset clears the valid pipeline and loads the default set corners; busy is high in reset.
module fuzzy_speed_angle_controller
  import fsac_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ANGLE_BITS-1:0]        in_angle,
  input  logic signed [SPEED_W-1:0]    in_speed,
  output logic                         out_valid,
  output logic [POWER_W-1:0]           out_power,
  output logic                         out_speed_clamped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CRD_W  = ((ANGLE_BITS > ANGREG_W) ? ANGLE_BITS : ANGREG_W) + 2;
  localparam int DIF_W  = CRD_W - 1;
  localparam int DIV_ST = MUQ_W / 2;
  localparam int QB     = OUT_FRAC_BITS + 1;
  localparam int FD_ST  = (QB + 1) / 2;
  localparam int FN_W   = NUM_W + OUT_FRAC_BITS + 1;
  localparam int FD_W   = DEN_W + 2;
  localparam int LAT    = 25 + FD_ST;
  localparam int SQ0    = 11;
  localparam int WS_IX  = SQ0 + SQ_ST + 1;
  localparam int FD0    = WS_IX + 1;
  localparam logic signed [CRD_W-1:0] FULL_TURN = CRD_W'(1) << ANGLE_BITS;
  localparam logic [31:0] PW_MAX =
    (OUT_FRAC_BITS >= 16) ? 32'hFFFF : (32'd1 << OUT_FRAC_BITS);

  typedef struct packed {
    mu_kind_t         kind;
    logic [DIF_W-1:0] x;
    logic [DIF_W-1:0] d;
  } tri_t;

  function automatic tri_t tri_setup(input logic signed [CRD_W-1:0] lo,
                                     input logic signed [CRD_W-1:0] pk,
                                     input logic signed [CRD_W-1:0] hi,
                                     input logic signed [CRD_W-1:0] v);
    tri_t t;
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dd;
    dx = '0;
    dd = '0;
    t.kind = MU_ZERO;
    if (v == pk) begin
      t.kind = MU_FULL;
    end else if (v < lo || v > hi) begin
      t.kind = MU_ZERO;
    end else if (v < pk) begin
      t.kind = MU_DIV;
      dx = v - lo;
      dd = pk - lo;
    end else begin
      t.kind = MU_DIV;
      dx = hi - v;
      dd = hi - pk;
    end
    t.x = dx[DIF_W-1:0];
    t.d = dd[DIF_W-1:0];
    return t;
  endfunction

  // Configuration registers.
  logic [LIMIT_W-1:0]  spd_lim_r, spd_knee_r;
  logic [ANGREG_W-1:0] ang_klo_r, ang_ctr_r, ang_khi_r;
  logic                busy_r;

  logic [LAT-1:0] vld_sr_r;
  logic [LAT-1:0] clp_sr_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_lim_r  <= 12'd1792;
      spd_knee_r <= 12'd358;
      ang_klo_r  <= 16'd26214;
      ang_ctr_r  <= 16'd32768;
      ang_khi_r  <= 16'd39322;
      busy_r     <= 1'b1;
      vld_sr_r   <= '0;
    end else begin
      busy_r   <= 1'b0;
      vld_sr_r <= {vld_sr_r[LAT-2:0], start & ~busy_r};
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPEED_LIMIT:     spd_lim_r  <= cfg_data[LIMIT_W-1:0];
          CFG_SPEED_KNEE:      spd_knee_r <= cfg_data[LIMIT_W-1:0];
          CFG_ANGLE_KNEE_LOW:  ang_klo_r  <= cfg_data;
          CFG_ANGLE_CENTER:    ang_ctr_r  <= cfg_data;
          CFG_ANGLE_KNEE_HIGH: ang_khi_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Corner points in the shared signed coordinate width.
  logic signed [CRD_W-1:0] lim_c, knee_c, klo_c, ctr_c, khi_c, zero_c;
  assign lim_c  = signed'(CRD_W'(spd_lim_r));
  assign knee_c = signed'(CRD_W'(spd_knee_r));
  assign klo_c  = signed'(CRD_W'(ang_klo_r));
  assign ctr_c  = signed'(CRD_W'(ang_ctr_r));
  assign khi_c  = signed'(CRD_W'(ang_khi_r));
  assign zero_c = '0;

  // Stage 1: speed clamp.
  logic signed [SPEED_W:0]  spd_ext;
  logic signed [SPEED_W:0]  lim_ext;
  logic signed [SPEED_W:0]  spd_cl;
  logic                     clp_nxt;
  logic signed [CRD_W-1:0]  ang1_r, spd1_r;

  always_comb begin
    spd_ext = (SPEED_W+1)'(in_speed);
    lim_ext = signed'((SPEED_W+1)'(spd_lim_r));
    spd_cl  = spd_ext;
    clp_nxt = 1'b0;
    if (spd_ext > lim_ext) begin
      spd_cl  = lim_ext;
      clp_nxt = 1'b1;
    end
    if (spd_ext < -lim_ext) begin
      spd_cl  = -lim_ext;
      clp_nxt = 1'b1;
    end
  end

  // Stage 2 and divider stages: five speed lanes, then five angle lanes.
  mu_kind_t          dv_kind_r [0:DIV_ST][NLANES];
  logic [DIF_W-1:0]  dv_rem_r  [0:DIV_ST][NLANES];
  logic [DIF_W-1:0]  dv_d_r    [0:DIV_ST][NLANES];
  logic [MUQ_W-1:0]  dv_q_r    [0:DIV_ST][NLANES];
  logic [DIF_W-1:0]  dv_rem_nxt[1:DIV_ST][NLANES];
  logic [MUQ_W-1:0]  dv_q_nxt  [1:DIV_ST][NLANES];
  tri_t              tri_nxt   [NLANES];

  always_comb begin
    tri_nxt[0] = tri_setup(-lim_c, -lim_c, -knee_c, spd1_r);
    tri_nxt[1] = tri_setup(-lim_c, -knee_c, zero_c, spd1_r);
    tri_nxt[2] = tri_setup(-knee_c, zero_c, knee_c, spd1_r);
    tri_nxt[3] = tri_setup(zero_c, knee_c, lim_c, spd1_r);
    tri_nxt[4] = tri_setup(knee_c, lim_c, lim_c, spd1_r);
    tri_nxt[5] = tri_setup(zero_c, zero_c, klo_c, ang1_r);
    tri_nxt[6] = tri_setup(zero_c, klo_c, ctr_c, ang1_r);
    tri_nxt[7] = tri_setup(klo_c, ctr_c, khi_c, ang1_r);
    tri_nxt[8] = tri_setup(ctr_c, khi_c, FULL_TURN, ang1_r);
    tri_nxt[9] = tri_setup(khi_c, FULL_TURN, FULL_TURN, ang1_r);
  end

  // Restoring division, two quotient bits per stage; the remainder stays below the divisor.
  always_comb begin
    logic [DIF_W-1:0] rem;
    logic [DIF_W:0]   rem2;
    logic [MUQ_W-1:0] q;
    for (int s = 1; s <= DIV_ST; s++) begin
      for (int l = 0; l < NLANES; l++) begin
        rem = dv_rem_r[s-1][l];
        q   = dv_q_r[s-1][l];
        for (int j = 0; j < 2; j++) begin
          rem2 = {rem, 1'b0};
          if (rem2 >= {1'b0, dv_d_r[s-1][l]}) begin
            rem2 = rem2 - {1'b0, dv_d_r[s-1][l]};
            q    = {q[MUQ_W-2:0], 1'b1};
          end else begin
            q    = {q[MUQ_W-2:0], 1'b0};
          end
          rem = rem2[DIF_W-1:0];
        end
        dv_rem_nxt[s][l] = rem;
        dv_q_nxt[s][l]   = q;
      end
    end
  end

  // Memberships, rule minimums and class sums.
  logic [MU_W-1:0] mu_val [NLANES];
  logic [MU_W-1:0] mn_r   [NRULES];
  logic [MU_W-1:0] mn_nxt [NRULES];
  logic [SUM_W-1:0] sum_nxt [NSETS];

  always_comb begin
    logic [MU_W-1:0] a;
    logic [MU_W-1:0] b;
    for (int l = 0; l < NLANES; l++) begin
      case (dv_kind_r[DIV_ST][l])
        MU_FULL: mu_val[l] = MU_ONE;
        MU_DIV:  mu_val[l] = {1'b0, dv_q_r[DIV_ST][l]};
        default: mu_val[l] = '0;
      endcase
    end
    for (int r = 0; r < NRULES; r++) begin
      a = mu_val[RULES[r].spd];
      b = mu_val[NSETS + int'(RULES[r].ang)];
      mn_nxt[r] = (a < b) ? a : b;
    end
  end

  always_comb begin
    for (int k = 0; k < NSETS; k++) begin
      sum_nxt[k] = '0;
    end
    for (int r = 0; r < NRULES; r++) begin
      sum_nxt[RULES[r].cls] = sum_nxt[RULES[r].cls] + SUM_W'(mn_r[r]);
    end
  end

  // Digit-by-digit square roots, two result bits per stage.
  logic [SQX_W-1:0]  sq_x_r    [0:SQ_ST][NSETS];
  logic [ROOT_W+1:0] sq_rem_r  [0:SQ_ST][NSETS];
  logic [ROOT_W-1:0] sq_root_r [0:SQ_ST][NSETS];
  logic [SQX_W-1:0]  sq_x_nxt    [1:SQ_ST][NSETS];
  logic [ROOT_W+1:0] sq_rem_nxt  [1:SQ_ST][NSETS];
  logic [ROOT_W-1:0] sq_root_nxt [1:SQ_ST][NSETS];

  always_comb begin
    logic [SQX_W-1:0]  x;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W+3:0] rw;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W-1:0] root;
    for (int s = 1; s <= SQ_ST; s++) begin
      for (int k = 0; k < NSETS; k++) begin
        x    = sq_x_r[s-1][k];
        rem  = sq_rem_r[s-1][k];
        root = sq_root_r[s-1][k];
        for (int j = 0; j < 2; j++) begin
          if ((s - 1) * 2 + j < SQ_IT) begin
            rw    = {rem, x[SQX_W-1 -: 2]};
            trial = {root, 2'b01};
            x     = {x[SQX_W-3:0], 2'b00};
            if (rw >= (ROOT_W+4)'(trial)) begin
              rw   = rw - (ROOT_W+4)'(trial);
              root = {root[ROOT_W-2:0], 1'b1};
            end else begin
              root = {root[ROOT_W-2:0], 1'b0};
            end
            rem = rw[ROOT_W+1:0];
          end
        end
        sq_x_nxt[s][k]    = x;
        sq_rem_nxt[s][k]  = rem;
        sq_root_nxt[s][k] = root;
      end
    end
  end

  // Weighted sums and the final rounding division.
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_nxt;
  logic [DEN_W-1:0] den_nxt;
  logic [FN_W-1:0]  fn_nxt;

  always_comb begin
    num_nxt = NUM_W'(sq_root_r[SQ_ST][1])
            + NUM_W'({sq_root_r[SQ_ST][2], 1'b0})
            + NUM_W'(sq_root_r[SQ_ST][3])
            + NUM_W'({sq_root_r[SQ_ST][3], 1'b0})
            + NUM_W'({sq_root_r[SQ_ST][4], 2'b00});
    den_nxt = '0;
    for (int k = 0; k < NSETS; k++) begin
      den_nxt = den_nxt + DEN_W'(sq_root_r[SQ_ST][k]);
    end
    fn_nxt = {1'b0, num_r, {OUT_FRAC_BITS{1'b0}}} + FN_W'({den_r, 1'b0});
  end

  logic [FD_W-1:0] fd_rem_r [0:FD_ST];
  logic [QB-1:0]   fd_lo_r  [0:FD_ST];
  logic [QB-1:0]   fd_q_r   [0:FD_ST];
  logic [FD_W-1:0] fd_d_r   [0:FD_ST];
  logic            fd_z_r   [0:FD_ST];
  logic [FD_W-1:0] fd_rem_nxt [1:FD_ST];
  logic [QB-1:0]   fd_lo_nxt  [1:FD_ST];
  logic [QB-1:0]   fd_q_nxt   [1:FD_ST];

  always_comb begin
    logic [FD_W-1:0] rem;
    logic [FD_W:0]   rem2;
    logic [QB-1:0]   lo;
    logic [QB-1:0]   q;
    for (int s = 1; s <= FD_ST; s++) begin
      rem = fd_rem_r[s-1];
      lo  = fd_lo_r[s-1];
      q   = fd_q_r[s-1];
      for (int j = 0; j < 2; j++) begin
        if ((s - 1) * 2 + j < QB) begin
          rem2 = {rem, lo[QB-1]};
          lo   = lo << 1;
          if (rem2 >= {1'b0, fd_d_r[s-1]}) begin
            rem2 = rem2 - {1'b0, fd_d_r[s-1]};
            q    = (q << 1) | QB'(1);
          end else begin
            q    = q << 1;
          end
          rem = rem2[FD_W-1:0];
        end
      end
      fd_rem_nxt[s] = rem;
      fd_lo_nxt[s]  = lo;
      fd_q_nxt[s]   = q;
    end
  end

  logic [QB+POWER_W-1:0] q_ext;
  logic [POWER_W-1:0]    pw_nxt;
  logic [POWER_W-1:0]    pw_r;

  always_comb begin
    q_ext = (QB+POWER_W)'(fd_q_r[FD_ST]);
    if (fd_z_r[FD_ST]) begin
      pw_nxt = '0;
    end else if (q_ext > (QB+POWER_W)'(16'hFFFF)) begin
      pw_nxt = 16'hFFFF;
    end else begin
      pw_nxt = q_ext[POWER_W-1:0];
    end
  end

  // Datapath registers, none reset; of the pipeline, only the valid chain above is reset.
  always_ff @(posedge clk) begin
    clp_sr_r <= {clp_sr_r[LAT-2:0], clp_nxt};
    ang1_r   <= signed'(CRD_W'(in_angle));
    spd1_r   <= CRD_W'(spd_cl);
    for (int l = 0; l < NLANES; l++) begin
      dv_kind_r[0][l] <= tri_nxt[l].kind;
      dv_rem_r[0][l]  <= tri_nxt[l].x;
      dv_d_r[0][l]    <= tri_nxt[l].d;
      dv_q_r[0][l]    <= '0;
      for (int s = 1; s <= DIV_ST; s++) begin
        dv_kind_r[s][l] <= dv_kind_r[s-1][l];
        dv_d_r[s][l]    <= dv_d_r[s-1][l];
        dv_rem_r[s][l]  <= dv_rem_nxt[s][l];
        dv_q_r[s][l]    <= dv_q_nxt[s][l];
      end
    end
    for (int r = 0; r < NRULES; r++) begin
      mn_r[r] <= mn_nxt[r];
    end
    for (int k = 0; k < NSETS; k++) begin
      sq_x_r[0][k]    <= {1'b0, sum_nxt[k], 16'h0000};
      sq_rem_r[0][k]  <= '0;
      sq_root_r[0][k] <= '0;
      for (int s = 1; s <= SQ_ST; s++) begin
        sq_x_r[s][k]    <= sq_x_nxt[s][k];
        sq_rem_r[s][k]  <= sq_rem_nxt[s][k];
        sq_root_r[s][k] <= sq_root_nxt[s][k];
      end
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    // The quotient fits QB bits, so the dividend above them is already below the divisor.
    fd_rem_r[0] <= FD_W'(fn_nxt[FN_W-1:QB]);
    fd_lo_r[0]  <= fn_nxt[QB-1:0];
    fd_q_r[0]   <= '0;
    fd_d_r[0]   <= {den_r, 2'b00};
    fd_z_r[0]   <= (den_r == '0);
    for (int s = 1; s <= FD_ST; s++) begin
      fd_rem_r[s] <= fd_rem_nxt[s];
      fd_lo_r[s]  <= fd_lo_nxt[s];
      fd_q_r[s]   <= fd_q_nxt[s];
      fd_d_r[s]   <= fd_d_r[s-1];
      fd_z_r[s]   <= fd_z_r[s-1];
    end
    pw_r <= pw_nxt;
  end

  assign out_valid         = vld_sr_r[LAT-1];
  assign out_power         = pw_r;
  assign out_speed_clamped = clp_sr_r[LAT-1];

`ifndef NO_ASSERTIONS
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_power) <= PW_MAX))
    else $error("power above the unit value");

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching transfer");

  a_mu_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_sr_r[DIV_ST+1] && dv_kind_r[DIV_ST][0] == MU_DIV)
      |-> (dv_rem_r[DIV_ST][0] < dv_d_r[DIV_ST][0]))
    else $error("membership divider remainder not below divisor");

  a_final_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_sr_r[FD0+FD_ST] && !fd_z_r[FD_ST]) |-> (fd_rem_r[FD_ST] < fd_d_r[FD_ST]))
    else $error("output divider remainder not below divisor");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the fuzzy speed and angle drive controller.
module testbench;
  import fsac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [POWER_W-1:0] power;
    logic               clamped;
  } drive_t;

  typedef struct {
    logic [15:0]              angle;
    logic signed [SPEED_W-1:0] speed;
    bit                       typed;
    logic [POWER_W-1:0]       power;
    logic                     clamped;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_angle = '0;
  logic signed [SPEED_W-1:0] in_speed = '0;
  logic out_valid;
  logic [POWER_W-1:0] out_power;
  logic out_speed_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the set corners.
  logic [LIMIT_W-1:0] lim_q, knee_q;
  logic [15:0] akl_q, acen_q, akh_q;

  drive_t pending_drive[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  fuzzy_speed_angle_controller dut (
    .clk, .rst_n, .start, .busy, .in_angle, .in_speed,
    .out_valid, .out_power, .out_speed_clamped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint membership(input longint lo, input longint pk, input longint hi,
                                        input longint v);
    if (v == pk) return 65536;
    if (v < lo || v > hi) return 0;
    if (v < pk) return ((v - lo) << 16) / (pk - lo);
    return ((hi - v) << 16) / (hi - pk);
  endfunction

  function automatic longint int_sqrt(input longint x);
    longint r, t;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic drive_t fuzzy_drive(input logic [15:0] ang, input logic signed [12:0] spd_in);
    drive_t d;
    longint spd, lim, kn, a, ms[5], ma[5], sums[5], num, den, rt, p, m;
    spd = spd_in;
    lim = lim_q;
    kn = knee_q;
    a = ang;
    d.clamped = 1'b0;
    if (spd > lim) begin
      spd = lim;
      d.clamped = 1'b1;
    end
    if (spd < -lim) begin
      spd = -lim;
      d.clamped = 1'b1;
    end
    ms[0] = membership(-lim, -lim, -kn, spd);
    ms[1] = membership(-lim, -kn, 0, spd);
    ms[2] = membership(-kn, 0, kn, spd);
    ms[3] = membership(0, kn, lim, spd);
    ms[4] = membership(kn, lim, lim, spd);
    ma[0] = membership(0, 0, akl_q, a);
    ma[1] = membership(0, akl_q, acen_q, a);
    ma[2] = membership(akl_q, acen_q, akh_q, a);
    ma[3] = membership(acen_q, akh_q, 65536, a);
    ma[4] = membership(akh_q, 65536, 65536, a);
    foreach (sums[k]) sums[k] = 0;
    for (int r = 0; r < NRULES; r++) begin
      m = ms[RULES[r].spd] < ma[RULES[r].ang] ? ms[RULES[r].spd] : ma[RULES[r].ang];
      sums[RULES[r].cls] += m;
    end
    num = 0;
    den = 0;
    for (int k = 0; k < 5; k++) begin
      rt = int_sqrt(sums[k] << 16);
      num += k * rt;
      den += rt;
    end
    if (den == 0) p = 0;
    else p = ((num << 15) + 2 * den) / (4 * den);
    d.power = (p > 65535) ? 16'hFFFF : p[15:0];
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_drive.size() == 0) begin
        report("unexpected transfer, power", out_power, -1);
      end else begin
        drive_t w;
        w = pending_drive.pop_front();
        if (out_power !== w.power) report("power", out_power, w.power);
        if (out_speed_clamped !== w.clamped) report("speed_clamped", out_speed_clamped, w.clamped);
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SPEED_LIMIT:     lim_q = val[11:0];
      CFG_SPEED_KNEE:      knee_q = val[11:0];
      CFG_ANGLE_KNEE_LOW:  akl_q = val;
      CFG_ANGLE_CENTER:    acen_q = val;
      CFG_ANGLE_KNEE_HIGH: akh_q = val;
      default: ;
    endcase
  endtask

  task automatic set_corners(input logic [15:0] l, input logic [15:0] k, input logic [15:0] lo,
                             input logic [15:0] c, input logic [15:0] hi);
    write_reg(CFG_SPEED_LIMIT, l);
    write_reg(CFG_SPEED_KNEE, k);
    write_reg(CFG_ANGLE_KNEE_LOW, lo);
    write_reg(CFG_ANGLE_CENTER, c);
    write_reg(CFG_ANGLE_KNEE_HIGH, hi);
  endtask

  // Expected results go in the queue at the accepting edge, under the current corners.
  task automatic send(input logic [15:0] ang, input logic signed [12:0] spd,
                      input bit typed, input drive_t want);
    start <= 1'b1;
    in_angle <= ang;
    in_speed <= spd;
    do @(posedge clk); while (busy);
    pending_drive.push_back(typed ? want : fuzzy_drive(ang, spd));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    logic [15:0] ang;
    logic signed [12:0] spd;
    drive_t none;
    none = '{power: '0, clamped: 1'b0};
    for (int i = 0; i < n; i++) begin
      ang = 16'($urandom);
      spd = 13'($urandom);
      case ($urandom_range(5))
        0: ang = 16'(akl_q + $urandom_range(4) - 2);
        1: ang = 16'(akh_q + $urandom_range(4) - 2);
        2: spd = 13'((($urandom_range(1) != 0) ? lim_q : -lim_q) + $urandom_range(4) - 2);
        3: spd = 13'((($urandom_range(1) != 0) ? knee_q : -knee_q) + $urandom_range(4) - 2);
        default: ;
      endcase
      if ($urandom_range(60) == 0) begin
        start <= 1'b0;
        while (pending_drive.size() != 0) @(posedge clk);
      end
      send(ang, spd, 1'b0, none);
    end
  endtask

  probe_t probes[] = '{
    '{16'd32768, 13'sd0,     1'b1, 16'd16384, 1'b0},
    '{16'd0,     13'sd4095,  1'b1, 16'd24576, 1'b1},
    '{16'd0,     -13'sd4096, 1'b1, 16'd32768, 1'b1},
    '{16'd65535, 13'sd0,     1'b0, 16'd0, 1'b0},
    '{16'd26214, 13'sd358,   1'b0, 16'd0, 1'b0},
    '{16'd39322, -13'sd358,  1'b0, 16'd0, 1'b0},
    '{16'd32767, 13'sd1792,  1'b0, 16'd0, 1'b0},
    '{16'd32769, 13'sd1793,  1'b0, 16'd0, 1'b0},
    '{16'd1,     -13'sd1792, 1'b0, 16'd0, 1'b0},
    '{16'd13107, -13'sd1793, 1'b0, 16'd0, 1'b0},
    '{16'd52428, 13'sd1,     1'b0, 16'd0, 1'b0},
    '{16'hAAAA,  13'sh0AAA,  1'b0, 16'd0, 1'b0},
    '{16'h5555,  13'sh1555,  1'b0, 16'd0, 1'b0},
    '{16'd20000, 13'sd900,   1'b0, 16'd0, 1'b0}
  };

  initial begin
    drive_t w;
    lim_q = 12'd1792;
    knee_q = 12'd358;
    akl_q = 16'd26214;
    acen_q = 16'd32768;
    akh_q = 16'd39322;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      w = '{power: probes[i].power, clamped: probes[i].clamped};
      send(probes[i].angle, probes[i].speed, probes[i].typed, w);
    end
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 13 : (ph < 6) ? 85 : 0;
      case (ph)
        0: set_corners(16'd4095, 16'd4095, 16'd65535, 16'd65535, 16'd65535);
        1: set_corners(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        // Zero limit clamps every nonzero speed to zero.
        2: set_corners(16'd0, 16'd200, 16'd16000, 16'd30000, 16'd50000);
        // Misordered corners: knee above the limit, angle knees on the wrong side of the center.
        3: set_corners(16'd300, 16'd2000, 16'd50000, 16'd20000, 16'd10000);
        4: set_corners(16'd4095, 16'd1, 16'd100, 16'd32768, 16'd65435);
        default: set_corners(16'($urandom_range(4095, 2000)), 16'($urandom_range(1999, 1)),
                             16'($urandom_range(30000, 1)), 16'($urandom_range(40000, 30001)),
                             16'($urandom_range(65535, 40001)));
      endcase
      random_items(65);
      settle();
    end
    set_corners(16'd1792, 16'd358, 16'd26214, 16'd32768, 16'd39322);
    random_items(20);
    settle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
